/* hdl/assert_macros.svh */
// Assertion macros used by the top level to check the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cpts_pkg.sv */
// Types, codes and helper functions of the counter priority task scheduler.
package cpts_pkg;

	// Request codes.
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_YIELD = 3'd1;
	localparam logic [2:0] REQ_LOAD  = 3'd2;
	localparam logic [2:0] REQ_SET   = 3'd3;
	localparam logic [2:0] REQ_REAP  = 3'd4;
	localparam logic [2:0] REQ_INC   = 3'd5;
	localparam logic [2:0] REQ_DEC   = 3'd6;

	// Task state codes.
	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_WAIT   = 2'd1;
	localparam logic [1:0] ST_ZOMBIE = 2'd2;

	// Best counter before any runnable slot is seen.
	localparam logic signed [7:0] SLICE_NONE = -8'sd1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] task_index;
		logic [1:0] task_state;
		logic [5:0] task_priority;
		logic [6:0] initial_slice;
	} req_t;

	typedef struct packed {
		logic [3:0]        current_task;
		logic              switched;
		logic [3:0]        free_slot;
		logic              free_found;
		logic signed [7:0] current_slice;
	} res_t;

	// One slot record as stored in the slot table.
	typedef struct packed {
		logic [1:0]        state;
		logic signed [7:0] slice;
		logic [5:0]        prio;
		logic signed [7:0] hold;
	} slot_rec_t;

	// Slot table strobes from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// Saturate a widened value to the signed 8-bit range.
	function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
		if (v > 10'sd127) begin
			return 8'sd127;
		end
		if (v < -10'sd128) begin
			return -8'sd128;
		end
		return v[7:0];
	endfunction

	// Recharge a counter: arithmetic half plus priority.
	function automatic logic signed [7:0] recharge(input logic signed [7:0] s,
			input logic [5:0] p);
		logic signed [9:0] h;
		h = $signed({s[7], s[7], s}) >>> 1;
		return sat8(h + $signed({4'b0000, p}));
	endfunction

endpackage

/* hdl/cpts_mem.sv */
// Slot table: memory with a registered read port and per-entry written bits.
module cpts_mem import cpts_pkg::*; #(
	parameter int SLOTS = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] raddr,
	input  logic [AW-1:0] waddr,
	input  slot_rec_t     wdata,
	output slot_rec_t     rdata
);

	slot_rec_t          mem [SLOTS];
	slot_rec_t          rd_q;
	logic [SLOTS-1:0]   written_q;
	logic               rd_wr_s1;
	logic               rd_zero_s1;
	slot_rec_t          reset_rec;

	// Write and read the array.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	// Track which entries hold written data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_wr_s1   <= 1'b0;
			rd_zero_s1 <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				written_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_wr_s1   <= written_q[raddr];
				rd_zero_s1 <= (raddr == '0);
			end
		end
	end

	// Return the reset record for entries never written.
	always_comb begin
		reset_rec       = '0;
		reset_rec.state = ST_RUN;
		reset_rec.prio  = rd_zero_s1 ? 6'd1 : 6'd0;
		rdata           = rd_wr_s1 ? rd_q : reset_rec;
	end

endmodule

/* hdl/cpts_seq.sv */
// Request sequencer: read-modify-write of slots, scans, recharge and result.
module cpts_seq import cpts_pkg::*; #(
	parameter int SLOTS = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  req_t          request,
	output logic          done,
	output res_t          result,
	output mem_ctl_t      mem_ctl,
	output logic [AW-1:0] raddr,
	output logic [AW-1:0] waddr,
	output slot_rec_t     wdata,
	input  slot_rec_t     rdata
);

	localparam int CW     = AW + 1;
	localparam int FREE_N = (SLOTS < 16) ? SLOTS : 16;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MOD  = 5'b00010,
		S_SCAN = 5'b00100,
		S_FRD  = 5'b01000,
		S_OUT  = 5'b10000
	} seq_state_t;

	typedef enum logic [1:0] {
		M_PICK = 2'd0,
		M_RECH = 2'd1,
		M_REAP = 2'd2
	} scan_mode_t;

	seq_state_t        state_q;
	scan_mode_t        mode_q;
	req_t              req_q;
	logic [AW-1:0]     tgt_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     before_q;
	logic [SLOTS-1:0]  present_q;
	logic [CW-1:0]     cnt_q;
	logic signed [7:0] best_q;
	logic [AW-1:0]     pick_q;
	logic              rv_s1;
	logic [AW-1:0]     ridx_s1;
	res_t              res_q;
	logic              done_q;

	logic              idx_ok;
	logic [AW-1:0]     req_idx;
	logic              scan_last;
	logic signed [7:0] cand;
	logic              elig;
	logic signed [7:0] best_nx;
	logic [AW-1:0]     pick_nx;
	logic              reap_hit;
	slot_rec_t         mod_rec;
	logic              mod_pick;
	logic signed [7:0] dec_slice;
	logic [3:0]        free_idx;
	logic              free_ok;

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign result  = res_q;
	assign idx_ok  = int'(request.task_index) < SLOTS;
	assign req_idx = AW'(request.task_index);
	assign scan_last = (cnt_q == CW'(SLOTS));

	// Compare the slot returned by the scan pipeline against the best so far.
	always_comb begin
		cand     = (mode_q == M_RECH) ? recharge(rdata.slice, rdata.prio) : rdata.slice;
		elig     = rv_s1 && (mode_q != M_REAP) && present_q[ridx_s1] &&
			(rdata.state == ST_RUN) && (cand > best_q);
		best_nx  = elig ? cand : best_q;
		pick_nx  = elig ? ridx_s1 : pick_q;
		reap_hit = rv_s1 && (mode_q == M_REAP) && present_q[ridx_s1] &&
			(rdata.state == ST_ZOMBIE) && (ridx_s1 != '0) && (ridx_s1 != cur_q);
	end

	// Modify the addressed slot record.
	always_comb begin
		mod_rec   = rdata;
		mod_pick  = 1'b0;
		dec_slice = sat8($signed({rdata.slice[7], rdata.slice[7], rdata.slice}) - 10'sd1);
		case (req_q.req_type)
			REQ_TICK: begin
				if (dec_slice > 8'sd0 || rdata.hold > 8'sd0) begin
					mod_rec.slice = dec_slice;
				end else begin
					mod_rec.slice = '0;
					mod_pick      = 1'b1;
				end
			end
			REQ_YIELD: begin
				mod_rec.slice = '0;
				mod_pick      = 1'b1;
			end
			REQ_SET: begin
				mod_rec.state = req_q.task_state;
			end
			REQ_INC: begin
				mod_rec.hold = sat8($signed({rdata.hold[7], rdata.hold[7], rdata.hold}) + 10'sd1);
			end
			REQ_DEC: begin
				mod_rec.hold = sat8($signed({rdata.hold[7], rdata.hold[7], rdata.hold}) - 10'sd1);
			end
			default: begin
				mod_rec = rdata;
			end
		endcase
	end

	// Drive the slot table ports.
	always_comb begin
		mem_ctl = '0;
		raddr   = cur_q;
		waddr   = ridx_s1;
		wdata   = mod_rec;
		case (state_q)
			S_IDLE: begin
				if (request.req_type == REQ_LOAD) begin
					mem_ctl.wr_en = start && idx_ok;
					waddr         = req_idx;
					wdata.state   = request.task_state;
					wdata.slice   = $signed({1'b0, request.initial_slice});
					wdata.prio    = request.task_priority;
					wdata.hold    = '0;
				end else begin
					mem_ctl.rd_en = start;
					raddr = (request.req_type == REQ_SET) ? req_idx : cur_q;
				end
			end
			S_MOD: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = tgt_q;
			end
			S_SCAN: begin
				mem_ctl.rd_en = !scan_last;
				raddr         = cnt_q[AW-1:0];
				mem_ctl.wr_en = rv_s1 && (mode_q == M_RECH) && present_q[ridx_s1];
				wdata.slice   = cand;
			end
			S_FRD: begin
				mem_ctl.rd_en = 1'b1;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// Find the lowest free slot among the addressable ones.
	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = FREE_N - 1; i >= 0; i--) begin
			if (!present_q[i]) begin
				free_idx = 4'(i);
				free_ok  = 1'b1;
			end
		end
	end

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= M_PICK;
			req_q     <= '0;
			tgt_q     <= '0;
			cur_q     <= '0;
			before_q  <= '0;
			present_q <= SLOTS'(1);
			cnt_q     <= '0;
			best_q    <= SLICE_NONE;
			pick_q    <= '0;
			rv_s1     <= 1'b0;
			ridx_s1   <= '0;
			res_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT);
			rv_s1  <= (state_q == S_SCAN) && !scan_last;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= request;
						before_q <= cur_q;
						tgt_q    <= (request.req_type == REQ_SET) ? req_idx : cur_q;
						cnt_q    <= '0;
						best_q   <= SLICE_NONE;
						pick_q   <= '0;
						case (request.req_type)
							REQ_TICK, REQ_YIELD, REQ_INC, REQ_DEC: begin
								state_q <= S_MOD;
							end
							REQ_SET: begin
								if (idx_ok && present_q[req_idx]) begin
									state_q <= S_MOD;
								end else begin
									state_q <= S_FRD;
								end
							end
							REQ_LOAD: begin
								if (idx_ok) begin
									present_q[req_idx] <= 1'b1;
								end
								state_q <= S_FRD;
							end
							REQ_REAP: begin
								mode_q  <= M_REAP;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_FRD;
							end
						endcase
					end
				end
				S_MOD: begin
					if (mod_pick) begin
						mode_q  <= M_PICK;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_SCAN: begin
					if (reap_hit) begin
						present_q[ridx_s1] <= 1'b0;
					end
					if (!scan_last) begin
						cnt_q   <= cnt_q + CW'(1);
						ridx_s1 <= cnt_q[AW-1:0];
						best_q  <= best_nx;
						pick_q  <= pick_nx;
					end else if (mode_q == M_PICK && best_nx == 8'sd0) begin
						// Everyone runnable is spent: recharge and pick again.
						mode_q <= M_RECH;
						cnt_q  <= '0;
						best_q <= SLICE_NONE;
						pick_q <= '0;
					end else begin
						if (mode_q != M_REAP) begin
							cur_q <= pick_nx;
						end
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					res_q.current_task  <= 4'(cur_q);
					res_q.switched      <= (cur_q != before_q);
					res_q.free_slot     <= free_idx;
					res_q.free_found    <= free_ok;
					res_q.current_slice <= rdata.slice;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/counter_priority_task_scheduler_top.sv */
// Top level of the counter priority task scheduler.
//
// Requests enter on request with start; one is taken at a rising edge where
// start is high and busy is low. Busy stays high until the result is out.
// Each request gives one result on result, valid for exactly one cycle while
// done is high; the receiver cannot stall it and must take it then. busy
// drops in the same cycle that done rises, so the next request may follow.
// Path from the accepting edge to the result: load, no-op and set state on
// an absent slot go straight to the final read; set state on a present slot,
// preempt count and a tick that does not pick first rewrite the slot; a reap
// scans the table once; a tick or yield that picks rewrites the slot and
// scans, and scans twice when every runnable counter is spent and the table
// is recharged. Scan length is set by the slot table's single read port: a
// scan reads one slot a cycle, and the recharge pass rewrites slots while it picks again.
// Reset (arst_n low) makes slot 0 present and running with priority one and
// clears every other slot; no clearing pass is needed, the slot table keeps a
// written bit per entry and unwritten entries read as the reset record.
`include "assert_macros.svh"

module counter_priority_task_scheduler_top import cpts_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	slot_rec_t     wdata;
	slot_rec_t     rdata;

	cpts_seq #(
		.SLOTS(SLOTS),
		.AW   (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result),
		.mem_ctl(mem_ctl),
		.raddr  (raddr),
		.waddr  (waddr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	cpts_mem #(
		.SLOTS(SLOTS),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.raddr (raddr),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// A result only appears once the sequencer is free again.
	`ASSERT_CLK(a_done_idle, !(done && busy), "result strobe while busy")
	// An accepted request keeps the block busy in the next cycle.
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
	// The table is never read and written at the same entry in one cycle.
	`ASSERT_CLK(a_no_rw_clash, !(mem_ctl.rd_en && mem_ctl.wr_en && raddr == waddr), "read/write clash")
	// Results never come in adjacent cycles.
	`ASSERT_NEXT(a_done_single, done, !done, "two results in adjacent cycles")

endmodule

/* bench/testbench.sv */
// Self-checking bench for the counter priority task scheduler: directed table, then random requests.
`timescale 1ns / 100ps

module testbench;
	import cpts_pkg::*;

	// Codes with no name in the package.
	localparam logic [2:0] REQ_NOP  = 3'd7;
	localparam logic [1:0] ST_OTHER = 2'd3;

	localparam int NUM_SLOTS   = 16;
	localparam int RAND_ITEMS  = 160;
	localparam int CALM_ITEMS  = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = NUM_SLOTS * 2 + 10;

	typedef struct {
		req_t req;
		bit   typed;
		res_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	res_t result;

	// Private copy of the slot table for prediction.
	bit                slot_used   [NUM_SLOTS];
	logic [1:0]        slot_mode   [NUM_SLOTS];
	logic signed [7:0] slot_credit [NUM_SLOTS];
	logic [5:0]        slot_weight [NUM_SLOTS];
	logic signed [7:0] slot_pin    [NUM_SLOTS];
	logic [3:0]        active_slot;

	res_t      due_results [$];
	plan_row_t plan [$];
	int        mismatches;
	int        n;
	int        k;

	counter_priority_task_scheduler_top #(.SLOTS(NUM_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	// Toggle the clock every half period.
	always #6 clk = ~clk;

	// Saturate to the signed 8-bit range.
	function automatic logic signed [7:0] clip8(input int v);
		if (v > 127) begin
			return 8'sd127;
		end
		if (v < -128) begin
			return -8'sd128;
		end
		return v[7:0];
	endfunction

	// Find the runnable slot with the largest non-negative credit, lowest index on ties.
	function automatic int best_credit(output logic [3:0] pick);
		int c;
		c = -1;
		pick = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_used[i] && slot_mode[i] == ST_RUN && int'(slot_credit[i]) > c) begin
				c = int'(slot_credit[i]);
				pick = i[3:0];
			end
		end
		return c;
	endfunction

	// Pick the next task; recharge once when every runnable credit is spent.
	function automatic void choose_next();
		int         b;
		logic [3:0] p;
		b = best_credit(p);
		if (b == 0) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot_used[i]) begin
					slot_credit[i] = clip8((int'(slot_credit[i]) >>> 1) + int'(slot_weight[i]));
				end
			end
			b = best_credit(p);
		end
		active_slot = p;
	endfunction

	// Apply one request to the private table and return the result it should give.
	function automatic res_t schedule_step(input req_t r);
		res_t       e;
		logic [3:0] prior;
		logic [3:0] idx;
		prior = active_slot;
		idx = r.task_index;
		case (r.req_type)
			REQ_TICK: begin
				slot_credit[active_slot] = clip8(int'(slot_credit[active_slot]) - 1);
				if (!(slot_credit[active_slot] > 0 || slot_pin[active_slot] > 0)) begin
					slot_credit[active_slot] = '0;
					choose_next();
				end
			end
			REQ_YIELD: begin
				slot_credit[active_slot] = '0;
				choose_next();
			end
			REQ_LOAD: begin
				slot_used[idx] = 1'b1;
				slot_mode[idx] = r.task_state;
				slot_credit[idx] = $signed({1'b0, r.initial_slice});
				slot_weight[idx] = r.task_priority;
				slot_pin[idx] = '0;
			end
			REQ_SET: begin
				if (slot_used[idx]) begin
					slot_mode[idx] = r.task_state;
				end
			end
			REQ_REAP: begin
				for (int i = 1; i < NUM_SLOTS; i++) begin
					if (slot_used[i] && slot_mode[i] == ST_ZOMBIE && i[3:0] != active_slot) begin
						slot_used[i] = 1'b0;
					end
				end
			end
			REQ_INC: slot_pin[active_slot] = clip8(int'(slot_pin[active_slot]) + 1);
			REQ_DEC: slot_pin[active_slot] = clip8(int'(slot_pin[active_slot]) - 1);
			default: begin
			end
		endcase
		e.free_slot = '0;
		e.free_found = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!slot_used[i] && !e.free_found) begin
				e.free_slot = i[3:0];
				e.free_found = 1'b1;
			end
		end
		e.current_task = active_slot;
		e.switched = (active_slot != prior);
		e.current_slice = slot_credit[active_slot];
		return e;
	endfunction

	// Random request, weighted toward ticks and loads of runnable tasks.
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 36) begin
			r.req_type = REQ_TICK;
		end else if (pick < 46) begin
			r.req_type = REQ_YIELD;
		end else if (pick < 66) begin
			r.req_type = REQ_LOAD;
		end else if (pick < 78) begin
			r.req_type = REQ_SET;
		end else if (pick < 84) begin
			r.req_type = REQ_REAP;
		end else if (pick < 90) begin
			r.req_type = REQ_INC;
		end else if (pick < 96) begin
			r.req_type = REQ_DEC;
		end else begin
			r.req_type = REQ_NOP;
		end
		r.task_index = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) begin
			r.task_state = ST_OTHER;
		end else if ($urandom_range(0, 1) == 0) begin
			r.task_state = ST_RUN;
		end else begin
			r.task_state = 2'($urandom_range(0, 2));
		end
		r.task_priority = ($urandom_range(0, 11) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
		r.initial_slice = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 8))
			: 7'($urandom_range(0, 127));
		return r;
	endfunction

	// Append one row to the directed table; the expected result is optional.
	task automatic add_row(input logic [2:0] op, input logic [3:0] idx, input logic [1:0] st,
			input logic [5:0] pr, input logic [6:0] sl, input bit typed = 1'b0,
			input logic [3:0] cur = '0, input logic sw = 1'b0, input logic [3:0] fs = '0,
			input logic ff = 1'b0, input logic signed [7:0] cs = '0);
		plan_row_t row;
		row.req = '{req_type: op, task_index: idx, task_state: st, task_priority: pr,
			initial_slice: sl};
		row.typed = typed;
		row.want = '{current_task: cur, switched: sw, free_slot: fs, free_found: ff,
			current_slice: cs};
		plan.push_back(row);
	endtask

	// Issue one request, optionally after an idle burst; hold it until accepted.
	task automatic send(input req_t r, input bit idle_ok, input bit typed, input res_t want);
		res_t e;
		if (idle_ok && $urandom_range(0, 2) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start = 1'b1;
		request = r;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		e = schedule_step(r);
		due_results.push_back(typed ? want : e);
		@(negedge clk);
	endtask

	task automatic flag_mismatch(input string what, input res_t want);
		mismatches++;
		if (mismatches <= 10) begin
			$display({"%0t: %s: want task %0d sw %0d free %0d/%0d slice %0d,",
				" got task %0d sw %0d free %0d/%0d slice %0d"},
				$realtime, what, want.current_task, want.switched, want.free_slot,
				want.free_found, want.current_slice, result.current_task, result.switched,
				result.free_slot, result.free_found, result.current_slice);
		end
	endtask

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				flag_mismatch("result with no request pending", '0);
			end else begin
				res_t want;
				want = due_results.pop_front();
				if (result.current_task !== want.current_task || result.switched !== want.switched
						|| result.free_slot !== want.free_slot
						|| result.free_found !== want.free_found
						|| result.current_slice !== want.current_slice) begin
					flag_mismatch("result mismatch", want);
				end
			end
		end
	end

	// Stop a hung run.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		mismatches = 0;

		// Mirror the reset table.
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_used[i] = (i == 0);
			slot_mode[i] = ST_RUN;
			slot_credit[i] = '0;
			slot_weight[i] = (i == 0) ? 6'd1 : 6'd0;
			slot_pin[i] = '0;
		end
		active_slot = '0;

		// Directed table: reset state, extremes, every request and corner case.
		add_row(REQ_TICK,  4'd0,  ST_RUN,    6'd0,  7'd0,   1'b1, 4'd0,  1'b0, 4'd1, 1'b1, 8'sd1);
		add_row(REQ_NOP,   4'd0,  ST_RUN,    6'd0,  7'd0,   1'b1, 4'd0,  1'b0, 4'd1, 1'b1, 8'sd1);
		add_row(REQ_LOAD,  4'd15, ST_RUN,    6'd63, 7'd126, 1'b1, 4'd0,  1'b0, 4'd1, 1'b1, 8'sd1);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0,   1'b1, 4'd15, 1'b1, 4'd1, 1'b1, 8'sd126);
		add_row(REQ_INC,   4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_TICK,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_LOAD,  4'd1,  ST_ZOMBIE, 6'd1,  7'd0);
		add_row(REQ_LOAD,  4'd2,  ST_WAIT,   6'd0,  7'd127);
		add_row(REQ_SET,   4'd9,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_LOAD,  4'd3,  ST_OTHER,  6'd5,  7'd40);
		add_row(REQ_REAP,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_DEC,   4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_DEC,   4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_TICK,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_LOAD,  4'd15, ST_RUN,    6'd1,  7'd1);
		add_row(REQ_TICK,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_SET,   4'd2,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_SET,   4'd2,  ST_ZOMBIE, 6'd0,  7'd0);
		add_row(REQ_REAP,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_REAP,  4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_SET,   4'd0,  ST_WAIT,   6'd0,  7'd0);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_SET,   4'd15, ST_WAIT,   6'd0,  7'd0);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_LOAD,  4'd4,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_YIELD, 4'd0,  ST_RUN,    6'd0,  7'd0);
		add_row(REQ_SET,   4'd0,  ST_RUN,    6'd0,  7'd0);

		// Hold reset, then release it away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table.
		for (n = 0; n < plan.size(); n++) begin
			send(plan[n].req, 1'b1, plan[n].typed, plan[n].want);
		end

		// Restart the running task at a zero counter, then saturate its hold and counter.
		send('{req_type: REQ_LOAD, task_index: active_slot, task_state: ST_RUN,
			task_priority: 6'd1, initial_slice: 7'd0}, 1'b1, 1'b0, '0);
		for (k = 0; k < 130; k++) begin
			send('{req_type: REQ_INC, default: '0}, 1'b1, 1'b0, '0);
		end
		for (k = 0; k < 132; k++) begin
			send('{req_type: REQ_TICK, default: '0}, 1'b1, 1'b0, '0);
		end

		// Random requests; no idling in the closing stretch.
		for (k = 0; k < RAND_ITEMS; k++) begin
			send(random_request(), k < RAND_ITEMS - CALM_ITEMS, 1'b0, '0);
		end
		start = 1'b0;

		// Drain the outstanding results, then let the block settle.
		for (n = 0; n < DRAIN_LIMIT && due_results.size() != 0; n++) begin
			@(posedge clk);
		end
		if (due_results.size() != 0) begin
			flag_mismatch("results missing at end of run", due_results[0]);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* counter_priority_task_scheduler_top.f */
+incdir+hdl
hdl/cpts_pkg.sv
hdl/cpts_mem.sv
hdl/cpts_seq.sv
hdl/counter_priority_task_scheduler_top.sv
bench/testbench.sv
